>>> sv/assert_macros.svh
// Assertion macros for the pedal plausibility RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define DPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/dpp_pkg.sv
// Types and constants of the pedal plausibility checker.
package dpp_pkg;

  // Operation codes of an input transaction
  localparam logic [2:0] OP_RUN    = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_START  = 3'd4;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_DZ_LOW  = 2'd0;
  localparam logic [1:0] REG_DZ_HIGH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [7:0]  DZ_LOW_RST  = 8'd20;
  localparam logic [7:0]  DZ_HIGH_RST = 8'd20;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // Datapath widths of the position division
  localparam int NUM_W  = 17;  // |(x - lo) * 255| <= 130050
  localparam int SPAN_W = 10;  // |hi - lo| <= 765
  localparam int QUOT_W = 8;

  localparam logic [7:0] POS_MAX = 8'd255;

  // span / 10 as (span * 205) >> 11, exact for 8-bit spans
  localparam logic [15:0] TOL_MUL   = 16'd205;
  localparam int          TOL_SHIFT = 11;
  localparam logic [4:0]  TOL_MAX   = 5'd25;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] rotary;
    logic [7:0] linear;
  } in_item_t;

  typedef struct packed {
    logic [7:0] position;
    logic       mismatch;
    logic       fault;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [SPAN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_SCAN,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

>>> sv/dual_pot_pedal_plausibility_top.sv
// Top level of the dual-potentiometer pedal plausibility checker.
// Cross-checks a rotary and a linear pedal potentiometer through a calibration
// map held in a single-port memory of MAP_ENTRIES bytes with registered read
// data. After reset a clearing pass zeroes the map, one entry a cycle; no input
// transaction is taken during it, register writes are. Every input transaction
// gives exactly one result transaction. A run sample passes through a map read,
// range arithmetic, and an 8-step serial divider that forms the position; when
// the position is zero or clamped to full scale the divider is skipped. A
// faulted run sample, map write, tick, start calibration and unused ops go
// straight to the result. Finish calibration walks the whole map through the
// memory port. One transaction is in work at a time; a finished result waits
// in the output register while the next transaction is accepted, and a result
// that finds the output register still full holds the block in its done state
// until the register drains.
`include "assert_macros.svh"

module dual_pot_pedal_plausibility_top #(
  parameter int MAP_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dpp_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(MAP_ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAP_ENTRIES - 1);

  // Configuration registers
  logic [7:0]  dz_low_r;
  logic [7:0]  dz_high_r;
  logic [15:0] timeout_r;
  logic        cfg_wr;

  // Control state
  dpp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          fault_r, fault_nxt;
  logic          running_r, running_nxt;
  logic [15:0]   timer_r, timer_nxt;
  logic [7:0]    rmin_r, rmin_nxt;
  logic [7:0]    rmax_r, rmax_nxt;
  logic [4:0]    tol_r, tol_nxt;
  logic          scan_vld_r, scan_vld_nxt;

  // Working payload
  dpp_pkg::out_item_t out_data_r, out_data_nxt;
  logic [7:0]    rot_r, rot_nxt;
  logic [7:0]    lin_r, lin_nxt;
  logic          oor_r, oor_nxt;
  logic [7:0]    res_pos_r, res_pos_nxt;
  logic          res_mis_r, res_mis_nxt;
  logic [18:0]   num_r, num_nxt;
  logic [10:0]   span_r, span_nxt;
  logic [7:0]    scan_idx_r, scan_idx_nxt;
  logic [7:0]    lmin_r, lmin_nxt;
  logic [7:0]    lmax_r, lmax_nxt;
  logic          any_r, any_nxt;

  // Memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  dpp_pkg::div_req_t div_req;
  dpp_pkg::div_rsp_t div_rsp;

  // Combinational helpers
  logic          in_acc;
  logic          in_range;
  logic [15:0]   timer_inc;
  logic [7:0]    map_val;
  logic signed [9:0]  m_s, l_s, t_s;
  logic          match;
  logic signed [10:0] lo_s, hi_s, x_s, diff_s;
  logic          num_neg, span_neg, pos_zero, pos_ovf;
  logic [18:0]   num_mag;
  logic [10:0]   span_mag;
  logic [dpp_pkg::NUM_W-1:0]  num_abs;
  logic [dpp_pkg::SPAN_W-1:0] span_abs;
  logic [7:0]    lspan;
  logic [15:0]   tol_prod;

  dpp_map_ram #(
    .DEPTH (MAP_ENTRIES),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  dpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_low_r  <= dpp_pkg::DZ_LOW_RST;
      dz_high_r <= dpp_pkg::DZ_HIGH_RST;
      timeout_r <= dpp_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dpp_pkg::REG_DZ_LOW:  dz_low_r  <= pwdata[7:0];
        dpp_pkg::REG_DZ_HIGH: dz_high_r <= pwdata[7:0];
        dpp_pkg::REG_TIMEOUT: timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dpp_pkg::REG_DZ_LOW:  prdata = {24'd0, dz_low_r};
      dpp_pkg::REG_DZ_HIGH: prdata = {24'd0, dz_high_r};
      dpp_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_r};
      default:              prdata = '0;
    endcase
  end

  // Input decode
  assign in_acc    = in_valid && in_ready;
  assign in_range  = 32'(in_data.rotary) < 32'(MAP_ENTRIES);
  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;

  // Tolerance check on the map entry just read
  assign map_val = oor_r ? 8'd0 : ram_rdata;
  assign m_s     = signed'({2'b00, map_val});
  assign l_s     = signed'({2'b00, lin_r});
  assign t_s     = signed'({5'd0, tol_r});
  assign match   = (m_s < l_s + t_s) && (m_s > l_s - t_s);

  // Dead-zone range and numerator of the position
  assign lo_s   = signed'({3'b000, rmin_r}) + signed'({3'b000, dz_low_r});
  assign hi_s   = signed'({3'b000, rmax_r}) - signed'({3'b000, dz_high_r});
  assign x_s    = signed'({3'b000, rot_r});
  assign diff_s = x_s - lo_s;

  // Sign and magnitude split ahead of the divider
  assign num_neg  = num_r[18];
  assign span_neg = span_r[10];
  assign num_mag  = num_neg ? (19'd0 - num_r) : num_r;
  assign span_mag = span_neg ? (11'd0 - span_r) : span_r;
  assign num_abs  = num_mag[dpp_pkg::NUM_W-1:0];
  assign span_abs = span_mag[dpp_pkg::SPAN_W-1:0];
  assign pos_zero = (span_r == '0) || (num_r == '0) || (num_neg != span_neg);
  assign pos_ovf  = {1'b0, num_abs} >= {span_abs, 8'd0};

  // Linear span / 10
  assign lspan    = lmax_r - lmin_r;
  assign tol_prod = 16'(lspan) * dpp_pkg::TOL_MUL;

  // Sequencer: next state, memory port and datapath updates
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    fault_nxt     = fault_r;
    running_nxt   = running_r;
    timer_nxt     = timer_r;
    rmin_nxt      = rmin_r;
    rmax_nxt      = rmax_r;
    tol_nxt       = tol_r;
    scan_vld_nxt  = 1'b0;
    scan_idx_nxt  = scan_idx_r;
    rot_nxt       = rot_r;
    lin_nxt       = lin_r;
    oor_nxt       = oor_r;
    res_pos_nxt   = res_pos_r;
    res_mis_nxt   = res_mis_r;
    num_nxt       = num_r;
    span_nxt      = span_r;
    lmin_nxt      = lmin_r;
    lmax_nxt      = lmax_r;
    any_nxt       = any_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = AW'(in_data.rotary);
    ram_wdata     = in_data.linear;
    div_req       = '0;

    // Fold in the map entry returned during a scan
    if (scan_vld_r && (ram_rdata != 8'd0)) begin
      any_nxt = 1'b1;
      if (scan_idx_r < rmin_r) rmin_nxt = scan_idx_r;
      if (scan_idx_r > rmax_r) rmax_nxt = scan_idx_r;
      if (ram_rdata < lmin_r) lmin_nxt = ram_rdata;
      if (ram_rdata > lmax_r) lmax_nxt = ram_rdata;
    end

    case (state_r)
      dpp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_r[AW-1:0];
        ram_wdata = 8'd0;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = dpp_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      dpp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rot_nxt     = in_data.rotary;
          lin_nxt     = in_data.linear;
          oor_nxt     = !in_range;
          res_pos_nxt = 8'd0;
          res_mis_nxt = 1'b0;
          state_nxt   = dpp_pkg::ST_DONE;
          case (in_data.op)
            dpp_pkg::OP_RUN: begin
              if (!fault_r) state_nxt = dpp_pkg::ST_READ;
            end
            dpp_pkg::OP_WRITE: begin
              ram_we = in_range;
            end
            dpp_pkg::OP_FINISH: begin
              rmin_nxt  = 8'hFF;
              rmax_nxt  = 8'h00;
              lmin_nxt  = 8'hFF;
              lmax_nxt  = 8'h00;
              any_nxt   = 1'b0;
              cnt_nxt   = '0;
              state_nxt = dpp_pkg::ST_SCAN;
            end
            dpp_pkg::OP_TICK: begin
              if (running_r && !fault_r) begin
                timer_nxt = timer_inc;
                if (timer_inc >= timeout_r) fault_nxt = 1'b1;
              end
            end
            dpp_pkg::OP_START: begin
              fault_nxt   = 1'b0;
              running_nxt = 1'b0;
              timer_nxt   = 16'd0;
            end
            default: ;
          endcase
        end
      end
      dpp_pkg::ST_READ: begin
        if (match) begin
          running_nxt = 1'b0;
          timer_nxt   = 16'd0;
        end else begin
          running_nxt = 1'b1;
          res_mis_nxt = 1'b1;
        end
        num_nxt   = (19'(diff_s) <<< 8) - 19'(diff_s);
        span_nxt  = hi_s - lo_s;
        state_nxt = dpp_pkg::ST_CALC;
      end
      dpp_pkg::ST_CALC: begin
        if (pos_zero) begin
          res_pos_nxt = 8'd0;
          state_nxt   = dpp_pkg::ST_DONE;
        end else if (pos_ovf) begin
          res_pos_nxt = dpp_pkg::POS_MAX;
          state_nxt   = dpp_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = num_abs;
          div_req.den   = span_abs;
          state_nxt     = dpp_pkg::ST_DIV;
        end
      end
      dpp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          res_pos_nxt = div_rsp.quot;
          state_nxt   = dpp_pkg::ST_DONE;
        end
      end
      dpp_pkg::ST_SCAN: begin
        // Issue one read a cycle; the last entry lands on the final pass
        if (cnt_r != CNT_END) begin
          ram_addr     = cnt_r[AW-1:0];
          scan_vld_nxt = 1'b1;
          scan_idx_nxt = 8'(cnt_r);
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          state_nxt = dpp_pkg::ST_FIN;
        end
      end
      dpp_pkg::ST_FIN: begin
        tol_nxt   = any_r ? tol_prod[dpp_pkg::TOL_SHIFT +: 5] : 5'd0;
        state_nxt = dpp_pkg::ST_DONE;
      end
      dpp_pkg::ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.position = res_pos_r;
          out_data_nxt.mismatch = res_mis_r;
          out_data_nxt.fault    = fault_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = dpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dpp_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpp_pkg::ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      fault_r     <= 1'b0;
      running_r   <= 1'b0;
      timer_r     <= 16'd0;
      rmin_r      <= 8'hFF;
      rmax_r      <= 8'h00;
      tol_r       <= 5'd0;
      scan_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      fault_r     <= fault_nxt;
      running_r   <= running_nxt;
      timer_r     <= timer_nxt;
      rmin_r      <= rmin_nxt;
      rmax_r      <= rmax_nxt;
      tol_r       <= tol_nxt;
      scan_vld_r  <= scan_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rot_r      <= rot_nxt;
    lin_r      <= lin_nxt;
    oor_r      <= oor_nxt;
    res_pos_r  <= res_pos_nxt;
    res_mis_r  <= res_mis_nxt;
    num_r      <= num_nxt;
    span_r     <= span_nxt;
    scan_idx_r <= scan_idx_nxt;
    lmin_r     <= lmin_nxt;
    lmax_r     <= lmax_nxt;
    any_r      <= any_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A nonzero count only exists while the timer runs
  `DPP_ASSERT_IMP(a_timer_needs_run, clk, rst_n, timer_r != 16'd0, running_r)
  // The fault only sets on an accepted tick transaction
  `DPP_ASSERT_IMP(a_fault_on_tick, clk, rst_n, $rose(fault_r),
                  $past(in_acc && (in_data.op == dpp_pkg::OP_TICK)))
  // Span / 10 of an 8-bit span never exceeds 25
  `DPP_ASSERT_IMP(a_tol_bound, clk, rst_n, 1'b1, tol_r <= dpp_pkg::TOL_MAX)
  // A divider start moves the sequencer into the divide wait state
  `DPP_ASSERT_NXT(a_div_start, clk, rst_n, div_req.start, state_r == dpp_pkg::ST_DIV)

endmodule

>>> sv/dpp_map_ram.sv
// Single-port synchronous map memory with registered read data.
module dpp_map_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

>>> sv/dpp_div.sv
// Restoring divider, one quotient bit per cycle; dividend below 256 * divisor.
module dpp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dpp_pkg::div_req_t req,
  output dpp_pkg::div_rsp_t rsp
);

  localparam int NW = dpp_pkg::NUM_W;
  localparam int QW = dpp_pkg::QUOT_W;
  localparam int SW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [dpp_pkg::SPAN_W-1:0] den_r, den_nxt;
  logic [QW-1:0] quot_r, quot_nxt;
  logic [NW-1:0] den_sh;
  logic          fits;

  assign den_sh = NW'(den_r) << step_r;
  assign fits   = rem_r >= den_sh;

  // Load on start, then settle one quotient bit per cycle from the top
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(QW - 1);
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quot_nxt = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[QW-2:0], fits};
      if (fits) begin
        rem_nxt = rem_r - den_sh;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> test/tb_dual_pot_pedal_plausibility_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dual-potentiometer pedal plausibility checker.
module tb_dual_pot_pedal_plausibility_top;

  // Spare op codes and the unmapped register slot
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  localparam int RESET_CYCLES    = 6;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 300;
  localparam int PHASE_ITEMS     = 190;
  localparam int NUM_PHASES      = 8;
  localparam int RANDOM_PHASE    = 5;
  localparam int LIMIT_NS        = 20_000_000;

  // Register settings per phase; the random phase draws its own
  localparam int PHASE_DZ_LOW  [NUM_PHASES] = '{20, 0, 255, 10, 0, 0, 128, 0};
  localparam int PHASE_DZ_HIGH [NUM_PHASES] = '{20, 0, 255, 5, 0, 0, 127, 255};
  localparam int PHASE_TIMEOUT [NUM_PHASES] = '{100, 1, 65535, 8, 0, 0, 12, 50};

  // Predicts one report per accepted transaction and checks the DUT against it
  class pedal_scoreboard;
    logic [7:0]  pedal_map [256];
    logic [7:0]  rot_min;
    logic [7:0]  rot_max;
    logic [4:0]  tol;
    logic        timer_on;
    logic        fault_on;
    logic [15:0] timer_cnt;
    logic [7:0]  dz_low;
    logic [7:0]  dz_high;
    logic [15:0] timeout;
    dpp_pkg::out_item_t expected_reports [$];
    int          errors;
    int          checked;
    int          runs;
    int          run_mismatches;
    int          faulted_runs;
    int          rescans;
    int          fault_latches;

    function new();
      foreach (pedal_map[i]) pedal_map[i] = '0;
      rot_min = 8'd255;
      rot_max = '0;
      tol = '0;
      timer_on = 1'b0;
      fault_on = 1'b0;
      timer_cnt = '0;
      dz_low = dpp_pkg::DZ_LOW_RST;
      dz_high = dpp_pkg::DZ_HIGH_RST;
      timeout = dpp_pkg::TIMEOUT_RST;
      errors = 0;
      checked = 0;
      runs = 0;
      run_mismatches = 0;
      faulted_runs = 0;
      rescans = 0;
      fault_latches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        dpp_pkg::REG_DZ_LOW:  dz_low = value[7:0];
        dpp_pkg::REG_DZ_HIGH: dz_high = value[7:0];
        dpp_pkg::REG_TIMEOUT: timeout = value[15:0];
        default: ;
      endcase
    endfunction

    // Linear map with dead zones, truncating division, clamped to 0..255
    function logic [7:0] pedal_position(logic [7:0] x);
      int lo;
      int hi;
      int span;
      int p;
      lo = int'(rot_min) + int'(dz_low);
      hi = int'(rot_max) - int'(dz_high);
      span = hi - lo;
      if (span == 0) return '0;
      p = ((int'(x) - lo) * 255) / span;
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      return p[7:0];
    endfunction

    // Recompute the rotary range and the tolerance from the nonzero entries
    function void rescan_map();
      int rmin;
      int rmax;
      int lmin;
      int lmax;
      bit any;
      rmin = 255;
      rmax = 0;
      lmin = 255;
      lmax = 0;
      any = 1'b0;
      for (int i = 0; i < 256; i++) begin
        if (pedal_map[i] != 8'd0) begin
          any = 1'b1;
          if (i < rmin) rmin = i;
          if (i > rmax) rmax = i;
          if (int'(pedal_map[i]) < lmin) lmin = int'(pedal_map[i]);
          if (int'(pedal_map[i]) > lmax) lmax = int'(pedal_map[i]);
        end
      end
      rot_min = rmin[7:0];
      rot_max = rmax[7:0];
      tol = any ? 5'((lmax - lmin) / 10) : 5'd0;
    endfunction

    function void note_sample(dpp_pkg::in_item_t it);
      dpp_pkg::out_item_t rep;
      int m;
      int l;
      int t;
      rep = '0;
      case (it.op)
        dpp_pkg::OP_RUN: begin
          runs++;
          if (!fault_on) begin
            m = int'(pedal_map[it.rotary]);
            l = int'(it.linear);
            t = int'(tol);
            if (m < l + t && m > l - t) begin
              timer_on = 1'b0;
              timer_cnt = '0;
            end else begin
              timer_on = 1'b1;
              rep.mismatch = 1'b1;
              run_mismatches++;
            end
            rep.position = pedal_position(it.rotary);
          end else begin
            faulted_runs++;
          end
        end
        dpp_pkg::OP_WRITE: pedal_map[it.rotary] = it.linear;
        dpp_pkg::OP_FINISH: begin
          rescan_map();
          rescans++;
        end
        dpp_pkg::OP_TICK: begin
          if (timer_on && !fault_on) begin
            if (timer_cnt != 16'hFFFF) timer_cnt++;
            if (timer_cnt >= timeout) begin
              fault_on = 1'b1;
              fault_latches++;
            end
          end
        end
        dpp_pkg::OP_START: begin
          fault_on = 1'b0;
          timer_on = 1'b0;
          timer_cnt = '0;
        end
        default: ;
      endcase
      rep.fault = fault_on;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(dpp_pkg::out_item_t got);
      dpp_pkg::out_item_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected report: position %0d mismatch %0b fault %0b",
                   got.position, got.mismatch, got.fault);
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      if (got.position !== want.position || got.mismatch !== want.mismatch ||
          got.fault !== want.fault) begin
        errors++;
        if (errors <= 10)
          $display("report %0d: expected position %0d mismatch %0b fault %0b, got %0d %0b %0b",
                   checked, want.position, want.mismatch, want.fault,
                   got.position, got.mismatch, got.fault);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  dpp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  dpp_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pedal_scoreboard sb = new();

  int         burst_left = 0;
  int         items_sent = 0;
  logic [7:0] cal_points [$];

  dual_pot_pedal_plausibility_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Offer one transaction, in bursts separated by random gaps
  task automatic send_item(logic [2:0] op, logic [7:0] rot, logic [7:0] lin);
    dpp_pkg::in_item_t it;
    int gap;
    it.op = op;
    it.rotary = rot;
    it.linear = lin;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(it);
    if (op <= dpp_pkg::OP_START) items_sent++;
  endtask

  // Write one register: setup, access, then idle
  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int dl, int dh, int to);
    apb_write(dpp_pkg::REG_DZ_LOW, 32'(dl));
    apb_write(dpp_pkg::REG_DZ_HIGH, 32'(dh));
    apb_write(dpp_pkg::REG_TIMEOUT, 32'(to));
  endtask

  // Drop valid and wait until every predicted report has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Start calibration, write a noisy linear map over a random range, finish
  task automatic calibrate();
    int a;
    int b;
    int lo_l;
    int hi_l;
    int n;
    int idx;
    int lin;
    if ($urandom_range(0, 7) == 0) begin
      a = 0;
      b = 255;
    end else begin
      a = $urandom_range(0, 120);
      b = $urandom_range(a + 1, 255);
    end
    lo_l = $urandom_range(1, 60);
    hi_l = $urandom_range(120, 255);
    n = $urandom_range(3, 12);
    cal_points.delete();
    send_item(dpp_pkg::OP_START, 8'($urandom), 8'($urandom));
    for (int k = 0; k < n; k++) begin
      idx = (k == 0) ? a : (k == 1) ? b : $urandom_range(a, b);
      lin = lo_l + ((idx - a) * (hi_l - lo_l)) / (b - a) + $urandom_range(0, 6) - 3;
      if (lin < 1) lin = 1;
      if (lin > 255) lin = 255;
      // clear an entry now and then
      if ($urandom_range(0, 15) == 0) lin = 0;
      send_item(dpp_pkg::OP_WRITE, idx[7:0], lin[7:0]);
      if (lin != 0) cal_points.push_back(idx[7:0]);
    end
    send_item(dpp_pkg::OP_FINISH, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] pick_rotary();
    if (cal_points.size() != 0 && $urandom_range(0, 9) < 7)
      return cal_points[$urandom_range(0, cal_points.size() - 1)];
    return 8'($urandom);
  endfunction

  // Run sample near the mapped value, so both sides of the tolerance show up
  task automatic run_sample();
    logic [7:0] rot;
    int m;
    int t;
    int lin;
    rot = pick_rotary();
    m = int'(sb.pedal_map[rot]);
    t = int'(sb.tol);
    if ($urandom_range(0, 4) == 0) lin = $urandom_range(0, 255);
    else lin = m + $urandom_range(0, 2 * t + 4) - (t + 2);
    if (lin < 0) lin = 0;
    if (lin > 255) lin = 255;
    send_item(dpp_pkg::OP_RUN, rot, lin[7:0]);
  endtask

  // Force a mismatch, then tick toward the timeout and probe the fault
  task automatic chase_fault();
    logic [7:0] rot;
    int m;
    int n;
    rot = pick_rotary();
    m = int'(sb.pedal_map[rot]);
    send_item(dpp_pkg::OP_RUN, rot, (m >= 128) ? 8'(m - 30) : 8'(m + 30));
    if (sb.timeout <= 16'd120) n = int'(sb.timeout) + $urandom_range(0, 2);
    else n = $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) run_sample();
      else send_item(dpp_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    end
    run_sample();
    send_item(dpp_pkg::OP_TICK, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 1) == 0)
      send_item(dpp_pkg::OP_START, 8'($urandom), 8'($urandom));
  endtask

  task automatic run_phase(int p);
    int dl;
    int dh;
    int to;
    int first;
    int pick;
    dl = (p == RANDOM_PHASE) ? $urandom_range(0, 40) : PHASE_DZ_LOW[p];
    dh = (p == RANDOM_PHASE) ? $urandom_range(0, 40) : PHASE_DZ_HIGH[p];
    to = (p == RANDOM_PHASE) ? $urandom_range(2, 30) : PHASE_TIMEOUT[p];
    settle();
    set_regs(dl, dh, to);
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) calibrate();
      else if (pick < 22) chase_fault();
      else if (pick < 85) repeat ($urandom_range(1, 6)) run_sample();
      else if (pick < 93)
        repeat ($urandom_range(1, 3))
          send_item(dpp_pkg::OP_TICK, 8'($urandom), 8'($urandom));
      else send_item(3'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Main stimulus
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty map, reversed span, spare ops, strict tolerance edges
    send_item(dpp_pkg::OP_FINISH, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_RUN, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_TICK, 8'd0, 8'd0);
    send_item(OP_SPARE_5, 8'd255, 8'd255);
    send_item(OP_SPARE_6, 8'd255, 8'd255);
    send_item(OP_SPARE_7, 8'd255, 8'd255);
    send_item(dpp_pkg::OP_WRITE, 8'd0, 8'd1);
    send_item(dpp_pkg::OP_WRITE, 8'd128, 8'd128);
    send_item(dpp_pkg::OP_WRITE, 8'd255, 8'd255);
    send_item(dpp_pkg::OP_FINISH, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_RUN, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_RUN, 8'd255, 8'd255);
    send_item(dpp_pkg::OP_RUN, 8'd128, 8'd153);
    send_item(dpp_pkg::OP_RUN, 8'd128, 8'd152);

    // No dead zones, one-tick timeout: latch, faulted run, clear
    settle();
    set_regs(0, 0, 1);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    send_item(dpp_pkg::OP_RUN, 8'd128, 8'd0);
    send_item(dpp_pkg::OP_TICK, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_RUN, 8'd128, 8'd128);
    send_item(dpp_pkg::OP_TICK, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_START, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_RUN, 8'd255, 8'd255);

    // Dead zones that meet: zero span
    settle();
    set_regs(100, 155, 65535);
    send_item(dpp_pkg::OP_RUN, 8'd200, 8'd0);
    send_item(dpp_pkg::OP_TICK, 8'd0, 8'd0);
    send_item(dpp_pkg::OP_RUN, 8'd0, 8'd1);
    send_item(dpp_pkg::OP_START, 8'd0, 8'd0);

    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d reports: %0d run samples, %0d out of tolerance, %0d while faulted",
             sb.checked, sb.runs, sb.run_mismatches, sb.faulted_runs);
    $display("%0d map rescans, %0d fault latches, %0d register phases, %0d mismatches",
             sb.rescans, sb.fault_latches, NUM_PHASES + 3, sb.errors);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("tb_dual_pot_pedal_plausibility_top: clean");
    end else begin
      $display("tb_dual_pot_pedal_plausibility_top: errors");
    end
    $finish;
  end

  // Result side: check every accepted report, stall on a pattern of its own
  initial begin
    int  cyc;
    int  mode;
    int  run_left;
    int  received;
    bit  held;
    bit  ready_now;
    cyc = 0;
    mode = 0;
    run_left = 0;
    received = 0;
    held = 1'b0;
    ready_now = 1'b1;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_report(out_data);
        received++;
      end
      // hold off once for a long stretch so the block backs up
      if (!held && received >= HOLD_OFF_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      cyc++;
      if (cyc % 250 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            ready_now = !ready_now;
            run_left = ready_now ? $urandom_range(1, 10) : $urandom_range(1, 12);
          end
          run_left--;
          out_ready <= ready_now;
        end
      endcase
    end
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("tb_dual_pot_pedal_plausibility_top: errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/dpp_pkg.sv
sv/dpp_map_ram.sv
sv/dpp_div.sv
sv/dual_pot_pedal_plausibility_top.sv
test/tb_dual_pot_pedal_plausibility_top.sv
